@@ rtl/pse_pkg.sv @@
package pse_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int Q_W         = 32;
  localparam int FRAC_W      = 16;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [2:0] {
    FN_PUSH    = 3'd0,
    FN_ADD     = 3'd1,
    FN_SUB     = 3'd2,
    FN_MUL     = 3'd3,
    FN_DIV     = 3'd4,
    FN_RESULT  = 3'd5,
    FN_UNKNOWN = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_FEW     = 3'd2,
    ST_ZERO    = 3'd3,
    ST_WRONG   = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_SECOND,
    RD_BOTTOM
  } rd_sel_t;

  typedef enum logic [1:0] {
    WB_ADDSUB,
    WB_MUL,
    WB_DIV
  } wb_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    push;
    logic    set_status;
    status_t status;
    logic    clr_depth;
    logic    pop;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_b;
    logic    cap_a;
    logic    cap_answer;
    logic    mul_cap;
    logic    div_start;
    logic    wb;
    wb_sel_t wb_sel;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  full;
    logic  depth_one;
    logic  few;
    logic  b_zero;
    logic  div_done;
    logic  out_free;
  } sts_t;

endpackage

@@ rtl/pse_div.sv @@
module pse_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [pse_pkg::Q_W-1:0] dividend,
  input  logic [pse_pkg::Q_W-1:0] divisor,
  output logic                   done,
  output logic [pse_pkg::Q_W-1:0] quotient,
  output logic                   ovf
);
  import pse_pkg::*;

  localparam int CNT_W = $clog2(Q_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [Q_W-1:0]   rem_r;
  logic [Q_W-1:0]   sh_r;
  logic [Q_W-1:0]   q_r;
  logic [Q_W-1:0]   dvs_r;
  logic             ovf_r;

  logic [Q_W:0]     trial;
  logic [Q_W:0]     diff;
  logic             ge;

  assign trial = {rem_r, sh_r[Q_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // upper dividend half seeds the remainder; quotient overflows if it already reaches or exceeds divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {{(Q_W-FRAC_W){1'b0}}, dividend[Q_W-1:FRAC_W]};
      sh_r  <= {dividend[FRAC_W-1:0], {(Q_W-FRAC_W){1'b0}}};
      q_r   <= '0;
      dvs_r <= divisor;
      ovf_r <= {{(Q_W-FRAC_W){1'b0}}, dividend[Q_W-1:FRAC_W]} >= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
      sh_r  <= {sh_r[Q_W-2:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
  assign ovf      = ovf_r;

endmodule

@@ rtl/pse_ctrl.sv @@
module pse_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pse_pkg::sts_t sts,
  output pse_pkg::cmd_t cmd
);
  import pse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RES,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (sts.func)
          FN_PUSH: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
            if (sts.few) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FEW;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_TOP;
              state_nxt  = S_RD_B;
            end
          end
          FN_RESULT: begin
            if (sts.depth_one) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_BOTTOM;
              state_nxt  = S_RES;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_WRONG;
              cmd.clr_depth  = 1'b1;
            end
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_UNKNOWN;
          end
        endcase
      end
      S_RES: begin
        cmd.cap_answer = 1'b1;
        cmd.clr_depth  = 1'b1;
        state_nxt      = S_DONE;
      end
      S_RD_B: begin
        cmd.cap_b  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SECOND;
        state_nxt  = S_RD_A;
      end
      S_RD_A: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (sts.func)
          FN_MUL: begin
            cmd.mul_cap = 1'b1;
            state_nxt   = S_MUL;
          end
          FN_DIV: begin
            if (sts.b_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_ZERO;
              cmd.pop        = 1'b1;
              state_nxt      = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            cmd.wb     = 1'b1;
            cmd.wb_sel = WB_ADDSUB;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_MUL: begin
        cmd.wb     = 1'b1;
        cmd.wb_sel = WB_MUL;
        state_nxt  = S_DONE;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.wb     = 1'b1;
          cmd.wb_sel = WB_DIV;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/pse_dp.sv @@
module pse_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pse_pkg::cmd_t           cmd,
  output pse_pkg::sts_t           sts,
  input  logic [2:0]              in_func,
  input  logic signed [31:0]      in_number,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_answer,
  output logic                    out_answer_valid,
  output logic                    out_saturated
);
  import pse_pkg::*;

  logic [Q_W-1:0]     mem [STACK_DEPTH];
  logic [Q_W-1:0]     rd_data_r;

  func_t              func_r;
  logic [Q_W-1:0]     number_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;
  logic [Q_W-1:0]     a_r;
  logic [Q_W-1:0]     b_r;
  logic [2*Q_W-1:0]   prod_r;

  status_t            res_status_r;
  logic [Q_W-1:0]     res_answer_r;
  logic               res_valid_r;
  logic               res_sat_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [Q_W-1:0]     out_answer_r;
  logic               out_answer_valid_r;
  logic               out_saturated_r;

  logic [ADDR_W-1:0]  top_addr;
  logic [ADDR_W-1:0]  sec_addr;
  logic [ADDR_W-1:0]  rd_addr;

  logic [Q_W-1:0]     mag_a;
  logic [Q_W-1:0]     mag_b;
  logic               neg;
  logic [Q_W:0]       as_sum;
  logic               as_ovf;
  logic [Q_W-1:0]     as_val;
  logic [Q_W:0]       mul_clip;
  logic [Q_W:0]       div_clip;
  logic [Q_W-1:0]     wb_val;
  logic               wb_sat;
  logic               out_free;

  logic               div_done;
  logic [Q_W-1:0]     div_q;
  logic               div_ovf;

  // {saturated, value} for a magnitude with a sign applied
  function automatic logic [Q_W:0] sclip(input logic [Q_W+FRAC_W-1:0] m, input logic n);
    logic [Q_W:0] r;
    if (n) begin
      if (m > (Q_W+FRAC_W)'(Q_MIN)) begin
        r = {1'b1, Q_MIN};
      end else begin
        r = {1'b0, Q_W'(0) - m[Q_W-1:0]};
      end
    end else begin
      if (m > (Q_W+FRAC_W)'(Q_MAX)) begin
        r = {1'b1, Q_MAX};
      end else begin
        r = {1'b0, m[Q_W-1:0]};
      end
    end
    return r;
  endfunction

  assign top_addr = ADDR_W'(depth_r - DEPTH_W'(1));
  assign sec_addr = ADDR_W'(depth_r - DEPTH_W'(2));

  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:    rd_addr = top_addr;
      RD_SECOND: rd_addr = sec_addr;
      RD_BOTTOM: rd_addr = '0;
      default:   rd_addr = '0;
    endcase
  end

  assign mag_a = a_r[Q_W-1] ? (Q_W'(0) - a_r) : a_r;
  assign mag_b = b_r[Q_W-1] ? (Q_W'(0) - b_r) : b_r;
  assign neg   = a_r[Q_W-1] ^ b_r[Q_W-1];

  assign as_sum = (func_r == FN_SUB) ? ({a_r[Q_W-1], a_r} - {b_r[Q_W-1], b_r})
                                     : ({a_r[Q_W-1], a_r} + {b_r[Q_W-1], b_r});
  assign as_ovf = as_sum[Q_W] ^ as_sum[Q_W-1];
  assign as_val = as_ovf ? (as_sum[Q_W] ? Q_MIN : Q_MAX) : as_sum[Q_W-1:0];

  assign mul_clip = sclip(prod_r[2*Q_W-1:FRAC_W], neg);
  assign div_clip = sclip(div_ovf ? (Q_W+FRAC_W)'({1'b1, {Q_W{1'b0}}})
                                  : (Q_W+FRAC_W)'(div_q), neg);

  always_comb begin
    case (cmd.wb_sel)
      WB_ADDSUB: begin
        wb_val = as_val;
        wb_sat = as_ovf;
      end
      WB_MUL: begin
        wb_val = mul_clip[Q_W-1:0];
        wb_sat = mul_clip[Q_W];
      end
      WB_DIV: begin
        wb_val = div_clip[Q_W-1:0];
        wb_sat = div_clip[Q_W];
      end
      default: begin
        wb_val = as_val;
        wb_sat = as_ovf;
      end
    endcase
  end

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .quotient (div_q),
    .ovf      (div_ovf)
  );

  always_comb begin
    depth_nxt = depth_r;
    if (cmd.clr_depth) begin
      depth_nxt = '0;
    end else if (cmd.push) begin
      depth_nxt = depth_r + DEPTH_W'(1);
    end else if (cmd.pop || cmd.wb) begin
      depth_nxt = depth_r - DEPTH_W'(1);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[depth_r[ADDR_W-1:0]] <= number_r;
    end else if (cmd.wb) begin
      mem[sec_addr] <= wb_val;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r       <= func_t'(in_func);
      number_r     <= in_number;
      res_status_r <= ST_OK;
      res_answer_r <= '0;
      res_valid_r  <= 1'b0;
      res_sat_r    <= 1'b0;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    if (cmd.cap_answer) begin
      res_answer_r <= rd_data_r;
      res_valid_r  <= 1'b1;
    end
    if (cmd.wb) begin
      res_sat_r <= wb_sat;
    end
    if (cmd.cap_b) begin
      b_r <= rd_data_r;
    end
    if (cmd.cap_a) begin
      a_r <= rd_data_r;
    end
    if (cmd.mul_cap) begin
      prod_r <= mag_a * mag_b;
    end
    if (cmd.out_load) begin
      out_status_r       <= res_status_r;
      out_answer_r       <= res_answer_r;
      out_answer_valid_r <= res_valid_r;
      out_saturated_r    <= res_sat_r;
    end
  end

  assign sts.func      = func_r;
  assign sts.full      = (depth_r == DEPTH_W'(STACK_DEPTH));
  assign sts.depth_one = (depth_r == DEPTH_W'(1));
  assign sts.few       = (depth_r < DEPTH_W'(2));
  assign sts.b_zero    = (b_r == '0);
  assign sts.div_done  = div_done;
  assign sts.out_free  = out_free;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_answer       = out_answer_r;
  assign out_answer_valid = out_answer_valid_r;
  assign out_saturated    = out_saturated_r;

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output register overwritten");

  a_wb_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb || cmd.pop) |-> depth_r >= DEPTH_W'(2))
    else $error("operator pop with fewer than two operands");

  a_answer_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_answer_valid_r) |-> (out_status_r == ST_OK && !out_saturated_r))
    else $error("answer flagged with error status");

  a_depth_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap_answer |=> depth_r == '0)
    else $error("stack not cleared by result request");

endmodule

@@ rtl/postfix_stack_evaluator.sv @@
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   in_func, in_number
// out      output     out_valid / out_stall out_status, out_answer, out_answer_valid,
//                                           out_saturated
//
// One item at a time. Push, result request, unknown, stack full and too few operand tokens
// finish soonest; add, subtract and zero divisor take longer, multiply longer still, and divide
// longest, as it runs the 32-step restoring divider.
// Stack reads go through the single registered read port of the stack memory.
// Reset: synchronous, active low; empties the stack and the output register.
// The next item is taken while a finished item waits under out_stall; a finished item that
// finds the output register still stalled waits for it.
module postfix_stack_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_answer,
  output logic               out_answer_valid,
  output logic               out_saturated
);
  import pse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pse_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_number        (in_number),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_answer       (out_answer),
    .out_answer_valid (out_answer_valid),
    .out_saturated    (out_saturated)
  );

endmodule
